// ===== rtl/sha256_hash_top_macros.svh =====
// assertion macros shared by the sha256 hasher rtl
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef SHA256_HASH_TOP_MACROS_SVH
`define SHA256_HASH_TOP_MACROS_SVH

// property that must hold at every edge outside reset
`define SHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition at one edge implies a check at the next edge
`define SHA_ASSERT_NEXT(lbl, cond, chk, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (chk)) else $error(msg);

`endif

// ===== rtl/sha256_pkg.sv =====
// constants, types and round functions for the sha256 hasher
// no dependencies; used by sha256_chain and sha256_hash_top
package sha256_pkg;

  localparam int CHAIN_DEPTH  = 8;
  localparam int CHAIN_ADDR_W = $clog2(CHAIN_DEPTH);

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [CHAIN_DEPTH] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // request from the sequencer to the chaining-state memory
  typedef struct packed {
    logic                    rd_en;
    logic [CHAIN_ADDR_W-1:0] rd_addr;
    logic                    wr_en;
    logic [CHAIN_ADDR_W-1:0] wr_addr;
    logic [31:0]             wr_data;
    logic                    restart;
  } chain_req_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch_fn(input logic [31:0] e, input logic [31:0] f,
                                        input logic [31:0] g);
    ch_fn = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj_fn(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
    maj_fn = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== rtl/sha256_chain.sv =====
// chaining-state memory of the sha256 hasher: 8 x 32 bits, one read and one write port
// registered read; entries not yet written read as the initial hash; depends on sha256_pkg
module sha256_chain
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  chain_req_t  req,
  output logic [31:0] rd_data,
  output logic        rd_vld
);

  logic [31:0]             mem [CHAIN_DEPTH];
  logic [CHAIN_DEPTH-1:0]  written;
  logic [31:0]             mem_q;
  logic                    written_q;
  logic [CHAIN_ADDR_W-1:0] addr_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    mem_q     <= mem[req.rd_addr];
    written_q <= written[req.rd_addr];
    addr_q    <= req.rd_addr;
  end

  // restart drops every entry back to the initial hash
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= req.rd_en;
      if (req.restart) begin
        written <= '0;
      end else if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = written_q ? mem_q : INIT_HASH[addr_q];

endmodule

// ===== rtl/sha256_hash_top.sv =====
// sha256 message hasher, top level: byte stream in, digest words out
// depends on sha256_pkg, sha256_chain and sha256_hash_top_macros.svh
//
// usage
//   input channel s_axis: one transfer per item. tuser = kind (0 appends the
//   byte in tdata to the message, 1 finishes the message; tdata is ignored).
//   output channel m_axis: eight transfers per finished message, tdata = digest
//   word, tuser = word index 0..7 (most significant word first), tlast on word 7.
// operation
//   data bytes are taken one per cycle while the block is idle. every 64th byte
//   starts a compression (load the chaining state from its memory, 64 rounds at one
//   round per cycle, add and write back), during which s_axis_tready is low.
//   a finish pads one byte per cycle up to the block end (one or two blocks,
//   each followed by a compression), then reads the chaining memory one word at
//   a time into the output register, each read waiting until the last word is in.
//   the sustained byte rate is set by byte loading and compression taking turns.
// reset and stalls
//   rst clears the control state and restores the initial hash values; no
//   clearing pass is needed. when m_axis_tready is low the digest read-out waits;
//   once the last word is in the output register the block takes new input
//   while that word is still waiting to be taken.
`include "sha256_hash_top_macros.svh"

module sha256_hash_top
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_WB,
    ST_DIGEST
  } state_t;

  state_t      state;
  logic [5:0]  fill;        // bytes held in the current block
  logic [5:0]  rnd;         // round number
  logic [3:0]  cnt;         // memory access count in load, write-back and read-out
  logic [2:0]  out_idx_next;
  logic [63:0] bit_len;
  logic        pad_first;   // 0x80 marker still to go
  logic        len_ok;      // length field goes into this block
  logic        final_blk;   // block holding the length field is being compressed

  logic [23:0] word_acc;    // bytes of the partial big-endian word
  logic [31:0] w [16];      // message schedule window, w[0] is the current word
  logic [31:0] v [8];       // working variables a..h

  logic [31:0] out_data;
  logic [2:0]  out_idx;
  logic        out_valid;
  logic        out_last;

  chain_req_t  chain_req;
  logic [31:0] chain_rd;
  logic        chain_rd_vld;

  logic        in_fire;
  logic        push_en;
  logic [7:0]  push_byte;
  logic [7:0]  len_byte;
  logic        blk_full;
  logic        can_issue;
  logic        out_load;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  sha256_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .req     (chain_req),
    .rd_data (chain_rd),
    .rd_vld  (chain_rd_vld)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // length field, big-endian: byte 56 carries bits 63:56
  assign len_byte = bit_len[{~fill[2:0], 3'b000} +: 8];

  // byte source for the block buffer: input stream or padding
  always_comb begin
    push_en   = 1'b0;
    push_byte = s_axis_tdata;
    if (state == ST_IDLE) begin
      push_en = in_fire && !s_axis_tuser;
    end else if (state == ST_PAD) begin
      push_en = 1'b1;
      if (pad_first) begin
        push_byte = PAD_BYTE;
      end else if (fill >= LEN_START && len_ok) begin
        push_byte = len_byte;
      end else begin
        push_byte = 8'h00;
      end
    end
  end

  assign blk_full = push_en && (fill == 6'd63);

  // one compression round and the schedule expansion
  assign t1 = v[7] + big_sig1(v[4]) + ch_fn(v[4], v[5], v[6]) + ROUND_K[rnd] + w[0];
  assign t2 = big_sig0(v[0]) + maj_fn(v[0], v[1], v[2]);
  assign w_new = small_sig1(w[14]) + w[9] + small_sig0(w[1]) + w[0];

  // read-out: issue a read only when the output register is free after this edge
  assign can_issue = (!out_valid || m_axis_tready) && !chain_rd_vld;
  assign out_load  = (state == ST_DIGEST) && chain_rd_vld;

  always_comb begin
    chain_req         = '0;
    chain_req.rd_addr = cnt[CHAIN_ADDR_W-1:0];
    chain_req.wr_addr = CHAIN_ADDR_W'(cnt - 4'd1);
    chain_req.wr_data = chain_rd + v[0];
    unique case (state)
      ST_LOAD: begin
        chain_req.rd_en = !cnt[3];
      end
      ST_WB: begin
        chain_req.rd_en = !cnt[3];
        chain_req.wr_en = chain_rd_vld;
      end
      ST_DIGEST: begin
        chain_req.rd_en   = !cnt[3] && can_issue;
        chain_req.restart = cnt[3] && chain_rd_vld;
      end
      default: begin
      end
    endcase
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      rnd       <= '0;
      cnt       <= '0;
      bit_len   <= '0;
      pad_first <= 1'b0;
      len_ok    <= 1'b0;
      final_blk <= 1'b0;
      out_valid <= 1'b0;
      out_idx_next <= '0;
    end else begin
      if (push_en) begin
        fill <= fill + 6'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && s_axis_tuser) begin
            state     <= ST_PAD;
            pad_first <= 1'b1;
            len_ok    <= (fill < LEN_START);
          end else if (in_fire) begin
            bit_len <= bit_len + 64'd8;
            if (blk_full) begin
              state <= ST_LOAD;
              cnt   <= '0;
            end
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (blk_full) begin
            final_blk <= len_ok;
            len_ok    <= 1'b1;
            state     <= ST_LOAD;
            cnt       <= '0;
          end
        end
        ST_LOAD: begin
          if (cnt == 4'd8) begin
            state <= ST_ROUND;
            rnd   <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_WB;
            cnt   <= '0;
          end
        end
        ST_WB: begin
          if (cnt == 4'd8) begin
            cnt <= '0;
            if (final_blk) begin
              state        <= ST_DIGEST;
              out_idx_next <= '0;
            end else if (pad_first || len_ok) begin
              state <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_DIGEST: begin
          if (chain_req.rd_en) begin
            cnt <= cnt + 4'd1;
          end
          if (out_load) begin
            out_idx_next <= out_idx_next + 3'd1;
          end
          // last word captured: back to the start of a new message
          if (chain_req.restart) begin
            state     <= ST_IDLE;
            bit_len   <= '0;
            fill      <= '0;
            final_blk <= 1'b0;
            len_ok    <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (push_en) begin
      if (fill[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= {word_acc, push_byte};
      end else begin
        word_acc <= {word_acc[15:0], push_byte};
      end
    end
    if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    // load shifts the chaining words in; write-back rotates them out
    if ((state == ST_LOAD || state == ST_WB) && chain_rd_vld) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i+1];
      end
      v[7] <= (state == ST_LOAD) ? chain_rd : v[0];
    end
    if (out_load) begin
      out_data <= chain_rd;
      out_idx  <= out_idx_next;
      out_last <= (out_idx_next == 3'd7);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_idx;
  assign m_axis_tlast  = out_last;

  `SHA_ASSERT_NEXT(a_round_step, state == ST_ROUND && rnd != 6'd63,
                   state == ST_ROUND && rnd == $past(rnd) + 6'd1, "round counter skipped")
  `SHA_ASSERT(a_load_block_empty, state != ST_LOAD || fill == 6'd0,
              "compression started with a partial block")
  `SHA_ASSERT(a_chain_ports_apart,
              !(chain_req.rd_en && chain_req.wr_en) || chain_req.rd_addr != chain_req.wr_addr,
              "chain read and write hit the same entry")
  `SHA_ASSERT_NEXT(a_digest_order, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                   !m_axis_tvalid || m_axis_tuser == $past(m_axis_tuser) + 3'd1,
                   "digest words out of order")

endmodule

// ===== tb/tb_sha256_hash_top.sv =====
// testbench for sha256_hash_top: byte messages in, digest words out, checked against
// a behavioral sha-256 held in this file; needs only the rtl of the hasher
`timescale 1ns / 1ps

module tb_sha256_hash_top;

  // item kinds carried on s_axis_tuser
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // one digest word as it should appear on the output stream
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  pos;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tuser = 1'b0;    // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] digest_word
  logic [2:0]  m_axis_tuser;           // [2:0] word_index
  logic        m_axis_tlast;           // last_word

  // predicted hasher state
  logic [31:0] chain_h [8];
  logic [7:0]  msg_block [64];
  int unsigned held_bytes;
  logic [63:0] done_bits;

  digest_word_t expected_digest [$];
  int mismatch_count = 0;
  bit steady_phase = 1'b0;   // no idling on either side once set

  sha256_hash_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sha-256 predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // fold the 64 buffered bytes into the chaining words
  function automatic void absorb_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    // full message schedule up front rather than a sliding window
    for (int i = 16; i < 64; i++) begin
      s0 = rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++)
      v[i] = chain_h[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r];
      t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain_h[i] = chain_h[i] + v[i];
  endfunction

  function automatic void restart_hash();
    chain_h    = START_HASH;
    held_bytes = 0;
    done_bits  = '0;
  endfunction

  // advance the predictor by one accepted input transfer
  function automatic void hash_item(input logic kind, input logic [7:0] data);
    digest_word_t dw;
    if (kind == KIND_DATA) begin
      msg_block[held_bytes] = data;
      held_bytes++;
      if (held_bytes == 64) begin
        absorb_block();
        done_bits  = done_bits + 64'd512;
        held_bytes = 0;
      end
    end else begin
      // finish: the data byte is ignored, pad and append the 64-bit length
      done_bits = done_bits + 64'(held_bytes * 8);
      msg_block[held_bytes] = PAD_MARK;
      held_bytes++;
      // not enough room for the length: one extra padding block
      if (held_bytes > 56) begin
        while (held_bytes < 64) begin
          msg_block[held_bytes] = 8'h00;
          held_bytes++;
        end
        absorb_block();
        held_bytes = 0;
      end
      while (held_bytes < 56) begin
        msg_block[held_bytes] = 8'h00;
        held_bytes++;
      end
      for (int i = 0; i < 8; i++)
        msg_block[56+i] = done_bits[63-8*i -: 8];
      absorb_block();
      for (int i = 0; i < 8; i++) begin
        dw.value = chain_h[i];
        dw.pos   = 3'(i);
        dw.last  = (i == 7);
        expected_digest.push_back(dw);
      end
      restart_hash();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random backpressure and result checking
  // ---------------------------------------------------------------------------

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0)
        stall--;
      else if (!steady_phase && $urandom_range(0, 4) == 0)
        stall = $urandom_range(1, 3);
      m_axis_tready <= (stall == 0);
    end
  end

  task automatic report_fault(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s", msg);
  endtask

  // compare every output transfer with the oldest predicted digest word
  always @(posedge clk) begin
    digest_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_digest.size() == 0) begin
        report_fault($sformatf("unexpected digest word %h index %0d last %b",
                               m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = expected_digest.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tuser !== want.pos ||
            m_axis_tlast !== want.last)
          report_fault($sformatf(
            "digest mismatch: expected %h index %0d last %b, got %h index %0d last %b",
            want.value, want.pos, want.last, m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // drive one item, wait for its transfer, then maybe leave a short gap
  task automatic send_item(input logic kind, input logic [7:0] data);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    hash_item(kind, data);
    if (!steady_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random bytes followed by a finish whose data byte is random too
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_item(KIND_DATA, 8'($urandom_range(0, 255)));
    send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // hold off the input until every predicted digest word has been taken
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_digest.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // finish with no data, byte field all ones and ignored
  task automatic test_empty_message();
    send_item(KIND_FINISH, 8'hff);
  endtask

  // "abc", then a two-byte message with the byte extremes; back to back checks restart
  task automatic test_short_messages();
    send_item(KIND_DATA, 8'h61);
    send_item(KIND_DATA, 8'h62);
    send_item(KIND_DATA, 8'h63);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hff);
    send_item(KIND_FINISH, 8'haa);
  endtask

  // new message only after the previous digest has fully left the block
  task automatic test_after_drain();
    wait_drained();
    send_item(KIND_DATA, 8'h55);
    send_item(KIND_FINISH, 8'h80);
    wait_drained();
  endtask

  // one full data block followed by a tail that needs the extra padding block,
  // then a short random message
  task automatic test_random_messages();
    send_message($urandom_range(120, 123));
    send_message($urandom_range(0, 3));
  endtask

  // closing stretch with no gaps in the input and no new stalls on the output
  task automatic test_no_idle();
    steady_phase = 1'b1;
    for (int m = 0; m < 2; m++)
      send_message($urandom_range(0, 4));
  endtask

  initial begin
    restart_hash();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_message();
    test_short_messages();
    test_after_drain();
    test_random_messages();
    test_no_idle();

    // let the last digest drain, then watch for stray output
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_400_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
